// File: design/bcdh_pkg.sv
`timescale 1ns / 1ps

package bcdh_pkg;

    // Event codes
    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_PRESS  = 3'd1;
    localparam logic [2:0] EV_HOLD   = 3'd2;
    localparam logic [2:0] EV_SINGLE = 3'd3;
    localparam logic [2:0] EV_DOUBLE = 3'd4;

    // Lock modes
    localparam logic [1:0] LK_NONE   = 2'd0;
    localparam logic [1:0] LK_HOLD   = 2'd1;
    localparam logic [1:0] LK_FIRST  = 2'd2;
    localparam logic [1:0] LK_SECOND = 2'd3;

    // Register indexes
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASED_VALUE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESSED_VALUE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TICKS      = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TICKS      = 8'd3;

    // Reset values of the registers
    localparam logic [7:0] RELEASED_VALUE_RST = 8'd1;
    localparam logic [7:0] PRESSED_VALUE_RST  = 8'd0;
    localparam logic [7:0] MIN_TICKS_RST      = 8'd3;
    localparam logic [7:0] MAX_TICKS_RST      = 8'd100;

    typedef struct packed {
        logic [7:0] released_value;
        logic [7:0] pressed_value;
        logic [7:0] min_ticks;
        logic [7:0] max_ticks;
    } cfg_t;

    typedef struct packed {
        logic [7:0] pressed_ticks;
        logic [7:0] released_ticks;
        logic [7:0] previous_sample;
        logic [1:0] lock_mode;
    } state_t;

    typedef struct packed {
        logic [2:0] event_code;
        logic       level_pressed;
        logic       level_released;
        logic       edge_pressed;
        logic       edge_released;
    } result_t;

endpackage

// File: design/bcdh_core.sv
`timescale 1ns / 1ps

module bcdh_core
(
    input  logic [7:0]       sample,
    input  bcdh_pkg::cfg_t   cfg,
    input  bcdh_pkg::state_t state,
    output bcdh_pkg::state_t state_next,
    output bcdh_pkg::result_t result
);
    import bcdh_pkg::*;

    logic [7:0] pt;
    logic [7:0] rt;
    logic [1:0] lk;
    logic [2:0] ev;
    logic       lp;
    logic       lr;
    logic       ep;
    logic       er;
    logic       bumped;

    // Decisions in fixed order; a later event write wins
    always_comb
    begin
        pt     = state.pressed_ticks;
        rt     = state.released_ticks;
        lk     = state.lock_mode;
        ev     = EV_NONE;
        lp     = 1'b0;
        lr     = 1'b0;
        ep     = 1'b0;
        er     = 1'b0;
        bumped = 1'b0;

        // pressed step
        if (sample == cfg.pressed_value)
        begin
            lp = 1'b1;
            if (pt <= cfg.max_ticks && pt != 8'hFF)
            begin
                pt = pt + 8'd1;
                if (pt == cfg.max_ticks)
                begin
                    ev = EV_HOLD;
                    lk = LK_HOLD;
                end
            end
            if (state.previous_sample == cfg.released_value)
            begin
                ep = 1'b1;
                if (rt < cfg.min_ticks)
                begin
                    if (lk == LK_FIRST)
                        lk = LK_SECOND;
                end
                else
                begin
                    ev = EV_PRESS;
                end
                pt = 8'd0;
            end
        end

        // released step
        if (sample == cfg.released_value)
        begin
            lr = 1'b1;
            if (rt <= cfg.max_ticks && rt != 8'hFF)
            begin
                rt     = rt + 8'd1;
                bumped = 1'b1;
            end
            if (bumped)
            begin
                if (rt >= cfg.min_ticks && lk == LK_FIRST)
                begin
                    ev = EV_SINGLE;
                    lk = LK_NONE;
                end
                if (rt == cfg.max_ticks)
                    lk = LK_NONE;
            end
            if (state.previous_sample == cfg.pressed_value)
            begin
                er = 1'b1;
                if (lk != LK_HOLD)
                begin
                    if (pt >= cfg.min_ticks)
                    begin
                        ev = EV_SINGLE;
                        lk = LK_NONE;
                    end
                    else if (lk == LK_SECOND)
                    begin
                        ev = EV_DOUBLE;
                        lk = LK_NONE;
                    end
                    else
                    begin
                        lk = LK_FIRST;
                    end
                end
                else
                begin
                    lk = LK_NONE;
                end
                rt = 8'd0;
            end
        end
    end

    assign state_next.pressed_ticks   = pt;
    assign state_next.released_ticks  = rt;
    assign state_next.previous_sample = sample;
    assign state_next.lock_mode       = lk;

    assign result.event_code     = ev;
    assign result.level_pressed  = lp;
    assign result.level_released = lr;
    assign result.edge_pressed   = ep;
    assign result.edge_released  = er;

endmodule

// File: design/button_click_double_hold_classifier.sv
`timescale 1ns / 1ps

// Key click, double-click and hold classifier.
// Sample channel: one key sample per item on sample, qualified by
// sample_valid; an item is taken on a rising edge with sample_valid high
// and sample_stall low. Every item gives exactly one result item.
// Result channel: event_code plus four level/edge flags, held in an output
// register and qualified by result_valid; taken when result_stall is low.
// result_valid is set the cycle after acceptance. Throughput is one item per
// cycle unless stalled: classifier state and output register are updated in
// the same cycle the item is taken, so items may follow back to back.
// While the receiver stalls a waiting result, sample_stall is raised and the
// result is held; the next item is taken in the cycle the result is taken.
// Configuration: write channel cfg_valid/cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high. Index 0 released value (also reloads
// the previous sample), 1 pressed value, 2 minimum ticks, 3 maximum ticks;
// other indexes are ignored. Write only while the block is idle.
// Reset (rst_n low, asynchronous) restores register defaults, clears the
// counters and lock mode and empties the output register.

module button_click_double_hold_classifier
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic [7:0]                    sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [2:0]                    event_code,
    output logic                          level_pressed,
    output logic                          level_released,
    output logic                          edge_pressed,
    output logic                          edge_released,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcdh_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data
);
    import bcdh_pkg::*;

    cfg_t    cfg_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    logic    result_valid_reg;
    logic    accept;
    logic    cfg_write;

    assign sample_stall = result_valid_reg & result_stall;
    assign accept       = sample_valid & ~sample_stall;
    assign cfg_ready    = 1'b1;
    assign cfg_write    = cfg_valid & cfg_ready;

    bcdh_core u_core
    (
        .sample     (sample),
        .cfg        (cfg_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.released_value <= RELEASED_VALUE_RST;
            cfg_reg.pressed_value  <= PRESSED_VALUE_RST;
            cfg_reg.min_ticks      <= MIN_TICKS_RST;
            cfg_reg.max_ticks      <= MAX_TICKS_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RELEASED_VALUE: cfg_reg.released_value <= cfg_data;
                REG_PRESSED_VALUE:  cfg_reg.pressed_value  <= cfg_data;
                REG_MIN_TICKS:      cfg_reg.min_ticks      <= cfg_data;
                REG_MAX_TICKS:      cfg_reg.max_ticks      <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Classifier state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.pressed_ticks   <= 8'd0;
            state_reg.released_ticks  <= 8'd0;
            state_reg.previous_sample <= RELEASED_VALUE_RST;
            state_reg.lock_mode       <= LK_NONE;
        end
        else if (cfg_write && cfg_index == REG_RELEASED_VALUE)
        begin
            state_reg.previous_sample <= cfg_data;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (accept)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    // Output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

    assign result_valid   = result_valid_reg;
    assign event_code     = result_reg.event_code;
    assign level_pressed  = result_reg.level_pressed;
    assign level_released = result_reg.level_released;
    assign edge_pressed   = result_reg.edge_pressed;
    assign edge_released  = result_reg.edge_released;

endmodule
